@@ src/dht_pkg.sv @@
// Shared constants, types and slot arithmetic for the double-hash table.
package dht_pkg;

  localparam int unsigned CAPACITY = 1021;
  localparam int unsigned SLOT_W   = $clog2(CAPACITY);
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned KEY_W    = 64;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_LIVE    = 2'd1,
    MARK_DELETED = 2'd2
  } mark_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_ERASED    = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_ERASE  = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_CHAIN_RD,
    S_CHAIN_CHK,
    S_CHAIN_HASH,
    S_MOVE_RD,
    S_MOVE_WR,
    S_DEL,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic  done;
    slot_t home;
  } hash_rsp_t;

  // probe stride: home mod (CAPACITY-1) plus one
  function automatic slot_t step_of(slot_t home);
    slot_t r;
    if (home == slot_t'(CAPACITY - 1)) r = slot_t'(1);
    else r = home + slot_t'(1);
    return r;
  endfunction

  // (pos + step) mod CAPACITY, both operands below CAPACITY
  function automatic slot_t next_slot(slot_t pos, slot_t step);
    logic [SLOT_W:0] s;
    s = {1'b0, pos} + {1'b0, step};
    if (s >= (SLOT_W+1)'(CAPACITY)) s = s - (SLOT_W+1)'(CAPACITY);
    return s[SLOT_W-1:0];
  endfunction

endpackage

@@ src/dht_hash.sv @@
// Multi-cycle key hash: six mix steps, then modulo CAPACITY by folding the high bits.
module dht_hash import dht_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [KEY_W-1:0] key_i,
  output hash_rsp_t        rsp_o
);

  localparam int unsigned MIX_STEPS = 6;
  // 64 -> 56 -> 48 -> 40 -> 32 -> 24 -> 16 bits, then two more folds bring it below 1024
  localparam int unsigned MOD_STEPS = 8;
  localparam int unsigned LAST      = MIX_STEPS + MOD_STEPS - 1;
  localparam int unsigned CNT_W     = $clog2(LAST + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [KEY_W-1:0] k_q, k_d;
  slot_t            rem_q, rem_d;
  logic             done_q, done_d;

  always_comb begin
    logic [KEY_W-1:0] hi;
    logic [KEY_W-1:0] f;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    k_d    = k_q;
    rem_d  = rem_q;
    done_d = 1'b0;
    hi     = '0;
    f      = '0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      k_d    = key_i;
      rem_d  = '0;
    end else if (busy_q) begin
      case (cnt_q)
        CNT_W'(0): k_d = ~k_q + (k_q << 15);
        CNT_W'(1): k_d = k_q ^ (k_q >> 12);
        CNT_W'(2): k_d = k_q + (k_q << 2);
        CNT_W'(3): k_d = k_q ^ (k_q >> 4);
        CNT_W'(4): k_d = (k_q << 11) + (k_q << 3) + k_q;  // times 2057
        CNT_W'(5): k_d = k_q ^ (k_q >> 16);
        default: begin
          // 1024 mod 1021 = 3: bits above the low ten come back in three times over
          hi  = k_q >> SLOT_W;
          f   = (hi << 1) + hi + (k_q & KEY_W'((1 << SLOT_W) - 1));
          k_d = f;
          // meaningful on the last fold, where f is below 1024
          if (f[SLOT_W-1:0] >= slot_t'(CAPACITY)) rem_d = f[SLOT_W-1:0] - slot_t'(CAPACITY);
          else rem_d = f[SLOT_W-1:0];
        end
      endcase
      if (cnt_q == CNT_W'(LAST)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.home = rem_q;

endmodule

@@ src/double_hash_table_insert_erase.sv @@
// Open-addressing double-hash table with insert and erase, one probe sequencer.
//
//  channel | dir | tdata                                 | tuser
//  s_axis  | in  | [63:0] key_handle, [127:64] hook_value | [0] command
//  m_axis  | out | [9:0] slot_index, [19:10] occupancy    | [2:0] status
//
// Each hash runs in the shared hash unit (14 steps, then the done flag); each probe is
// one read of the slot memories plus one check state. Erase then walks the chain from
// the matched slot, rehashing each live chain slot, and ends with the move.
// After reset a pass over all 1021 slots clears the slot marks; no request is taken then.
// A finished result sits in the output register; the next request is taken
// while it waits, and the block stalls only when a second result is ready.
module double_hash_table_insert_erase import dht_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [127:0]   s_axis_tdata,   // [63:0] key_handle, [127:64] hook_value
  input  logic           s_axis_tuser,   // [0] command
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [23:0]    m_axis_tdata,   // [9:0] slot_index, [19:10] occupancy, zeros
  output logic [2:0]     m_axis_tuser    // [2:0] status
);

  state_e state_q, state_d;

  logic               cmd_q;
  logic [KEY_W-1:0]   key_q, hook_q;
  slot_t              home_q, step_q, pos_q, mv_q, last_q, clr_q;
  logic [COUNT_W-1:0] count_q;
  status_e            res_status_q;
  slot_t              res_slot_q;

  logic               out_valid_q;
  status_e            out_status_q;
  slot_t              out_slot_q;
  logic [SLOT_W-1:0]  out_occ_q;

  // slot memories
  logic [1:0]       mark_mem [CAPACITY];
  logic [KEY_W-1:0] key_mem  [CAPACITY];
  logic [KEY_W-1:0] hook_mem [CAPACITY];
  logic [1:0]       mark_rd_q;
  logic [KEY_W-1:0] key_rd_q, hook_rd_q;

  logic             mark_we, kv_we;
  slot_t            mark_waddr, kv_waddr, rd_addr;
  logic [1:0]       mark_wdata;
  logic [KEY_W-1:0] key_wdata, hook_wdata;

  logic             hash_start;
  logic [KEY_W-1:0] hash_key;
  hash_rsp_t        hash_rsp;

  logic  accept, out_free, key_eq, match;
  slot_t cur, nxt;

  dht_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (hash_key),
    .rsp_o   (hash_rsp)
  );

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign key_eq   = key_rd_q == key_q;
  assign match    = mark_rd_q == MARK_LIVE && key_eq && hook_rd_q == hook_q;
  assign cur      = (state_q == S_PROBE_CHK) ? pos_q : mv_q;
  assign nxt      = next_slot(cur, step_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:    if (clr_q == slot_t'(CAPACITY - 1)) state_d = S_IDLE;
      S_IDLE:     if (s_axis_tvalid) state_d = S_HASH;
      S_HASH:     if (hash_rsp.done) state_d = S_PROBE_RD;
      S_PROBE_RD: state_d = S_PROBE_CHK;
      S_PROBE_CHK: begin
        if (cmd_q == CMD_INSERT) begin
          if (mark_rd_q != MARK_LIVE || key_eq || nxt == home_q) state_d = S_RESULT;
          else state_d = S_PROBE_RD;
        end else begin
          if (mark_rd_q == MARK_EMPTY) state_d = S_RESULT;
          else if (match) state_d = S_CHAIN_RD;
          else if (nxt == home_q) state_d = S_RESULT;
          else state_d = S_PROBE_RD;
        end
      end
      S_CHAIN_RD: state_d = S_CHAIN_CHK;
      S_CHAIN_CHK: begin
        if (mark_rd_q == MARK_EMPTY) state_d = S_MOVE_RD;
        else if (mark_rd_q == MARK_LIVE) state_d = S_CHAIN_HASH;
        else if (nxt == pos_q) state_d = S_MOVE_RD;
        else state_d = S_CHAIN_RD;
      end
      S_CHAIN_HASH: begin
        if (hash_rsp.done) state_d = (nxt == pos_q) ? S_MOVE_RD : S_CHAIN_RD;
      end
      S_MOVE_RD:  state_d = S_MOVE_WR;
      S_MOVE_WR:  state_d = S_DEL;
      S_DEL:      state_d = S_RESULT;
      S_RESULT:   if (out_free) state_d = S_IDLE;
      default:    state_d = S_CLEAR;
    endcase
  end

  // memory ports and hash control
  always_comb begin
    s_axis_tready = state_q == S_IDLE;
    hash_start    = 1'b0;
    hash_key      = s_axis_tdata[KEY_W-1:0];
    mark_we       = 1'b0;
    mark_waddr    = pos_q;
    mark_wdata    = MARK_LIVE;
    kv_we         = 1'b0;
    kv_waddr      = pos_q;
    key_wdata     = key_q;
    hook_wdata    = hook_q;
    rd_addr       = pos_q;
    case (state_q)
      S_CLEAR: begin
        mark_we    = 1'b1;
        mark_waddr = clr_q;
        mark_wdata = MARK_EMPTY;
      end
      S_IDLE:     hash_start = s_axis_tvalid;
      S_PROBE_CHK: begin
        if (cmd_q == CMD_INSERT && mark_rd_q != MARK_LIVE) begin
          mark_we = 1'b1;
          kv_we   = 1'b1;
        end
      end
      S_CHAIN_RD: rd_addr = mv_q;
      S_CHAIN_CHK: begin
        rd_addr  = mv_q;
        hash_key = key_rd_q;
        hash_start = mark_rd_q == MARK_LIVE;
      end
      S_MOVE_RD:  rd_addr = last_q;
      S_MOVE_WR: begin
        // last chain entry moves into the erased slot
        mark_we    = 1'b1;
        mark_wdata = mark_rd_q;
        kv_we      = 1'b1;
        key_wdata  = key_rd_q;
        hook_wdata = hook_rd_q;
      end
      S_DEL: begin
        mark_we    = 1'b1;
        mark_waddr = last_q;
        mark_wdata = MARK_DELETED;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) mark_mem[mark_waddr] <= mark_wdata;
    if (kv_we) begin
      key_mem[kv_waddr]  <= key_wdata;
      hook_mem[kv_waddr] <= hook_wdata;
    end
    mark_rd_q <= mark_mem[rd_addr];
    key_rd_q  <= key_mem[rd_addr];
    hook_rd_q <= hook_mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + slot_t'(1);
      if (state_q == S_PROBE_CHK && cmd_q == CMD_INSERT && mark_rd_q != MARK_LIVE)
        count_q <= count_q + COUNT_W'(1);
      if (state_q == S_DEL && count_q != '0) count_q <= count_q - COUNT_W'(1);
      if (state_q == S_RESULT && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        cmd_q  <= s_axis_tuser;
        key_q  <= s_axis_tdata[KEY_W-1:0];
        hook_q <= s_axis_tdata[2*KEY_W-1:KEY_W];
      end
      S_HASH: begin
        home_q <= hash_rsp.home;
        step_q <= step_of(hash_rsp.home);
        pos_q  <= hash_rsp.home;
      end
      S_PROBE_CHK: begin
        if (cmd_q == CMD_INSERT) begin
          if (mark_rd_q != MARK_LIVE) begin
            res_status_q <= ST_INSERTED;
            res_slot_q   <= pos_q;
          end else begin
            res_slot_q <= '0;
            pos_q      <= nxt;
            if (key_eq) res_status_q <= ST_DUPLICATE;
            else res_status_q <= ST_FULL;
          end
        end else begin
          res_status_q <= ST_NOT_FOUND;
          res_slot_q   <= '0;
          if (match) begin
            mv_q   <= pos_q;
            last_q <= pos_q;
          end else begin
            pos_q <= nxt;
          end
        end
      end
      S_CHAIN_CHK: begin
        if (mark_rd_q != MARK_EMPTY && mark_rd_q != MARK_LIVE) mv_q <= nxt;
      end
      S_CHAIN_HASH: begin
        if (hash_rsp.done) begin
          if (hash_rsp.home == home_q) last_q <= mv_q;
          mv_q <= nxt;
        end
      end
      S_DEL: begin
        res_status_q <= ST_ERASED;
        res_slot_q   <= last_q;
      end
      S_RESULT: begin
        if (out_free) begin
          out_status_q <= res_status_q;
          out_slot_q   <= res_slot_q;
          out_occ_q    <= count_q[SLOT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_occ_q, out_slot_q};
  assign m_axis_tuser  = out_status_q;

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_W'(CAPACITY))
    else $error("live count above capacity");

  a_accept_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_HASH)
    else $error("request taken without starting the hash");

  a_out_from_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESULT))
    else $error("result shown without a finished request");

  a_move_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DEL |-> $past(state_q == S_MOVE_WR))
    else $error("slot freed before the chain move");

endmodule

@@ tb/dht_checker.sv @@
// Scoreboard for the double-hash table: predicts each request's result and compares.
module dht_checker import dht_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [23:0]  m_axis_tdata,
  input  logic [2:0]   m_axis_tuser,
  output int           errors_o,
  output int           pending_o
);

  typedef struct packed {
    status_e     status;
    slot_t       slot;
    logic [9:0]  occ;
  } outcome_t;

  mark_e       tbl_mark [CAPACITY];
  logic [63:0] tbl_key  [CAPACITY];
  logic [63:0] tbl_hook [CAPACITY];
  int          live_cnt;
  outcome_t    outcome_q[$];

  function automatic logic [63:0] key_mix(logic [63:0] k);
    k = ~k + (k << 15);
    k = k ^ (k >> 12);
    k = k + (k << 2);
    k = k ^ (k >> 4);
    k = k * 64'd2057;
    k = k ^ (k >> 16);
    return k;
  endfunction

  function automatic int home_slot(logic [63:0] k);
    return int'(key_mix(k) % 64'(CAPACITY));
  endfunction

  // apply one request to the shadow table and return what the block should report
  function automatic outcome_t table_apply(cmd_e cmd, logic [63:0] k, logic [63:0] h);
    outcome_t r;
    int home, stride, pos, last, mv;
    bit hit;
    home   = home_slot(k);
    stride = home % (CAPACITY - 1) + 1;
    pos    = home;
    hit    = 0;
    r.slot = '0;
    if (cmd == CMD_INSERT) begin
      r.status = ST_FULL;
      for (int n = 0; n < CAPACITY; n++) begin
        if (tbl_mark[pos] != MARK_LIVE) begin
          hit = 1;
          break;
        end
        if (tbl_key[pos] == k) begin
          r.status = ST_DUPLICATE;
          break;
        end
        pos = (pos + stride) % CAPACITY;
        if (pos == home) break;
      end
      if (hit) begin
        tbl_mark[pos] = MARK_LIVE;
        tbl_key[pos]  = k;
        tbl_hook[pos] = h;
        live_cnt++;
        r.status = ST_INSERTED;
        r.slot   = slot_t'(pos);
      end
    end else begin
      r.status = ST_NOT_FOUND;
      for (int n = 0; n < CAPACITY; n++) begin
        if (tbl_mark[pos] == MARK_EMPTY) break;
        if (tbl_mark[pos] == MARK_LIVE && tbl_key[pos] == k && tbl_hook[pos] == h) begin
          hit = 1;
          break;
        end
        pos = (pos + stride) % CAPACITY;
        if (pos == home) break;
      end
      if (hit) begin
        last = pos;
        mv   = pos;
        // last live entry of this chain sharing the same home slot
        for (int n = 0; n < CAPACITY; n++) begin
          if (tbl_mark[mv] == MARK_EMPTY) break;
          if (tbl_mark[mv] == MARK_LIVE && home_slot(tbl_key[mv]) == home) last = mv;
          mv = (mv + stride) % CAPACITY;
          if (mv == pos) break;
        end
        tbl_key[pos]   = tbl_key[last];
        tbl_hook[pos]  = tbl_hook[last];
        tbl_mark[pos]  = tbl_mark[last];
        tbl_mark[last] = MARK_DELETED;
        if (live_cnt > 0) live_cnt--;
        r.status = ST_ERASED;
        r.slot   = slot_t'(last);
      end
    end
    r.occ = 10'(live_cnt);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t exp_o;
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY; i++) begin
        tbl_mark[i] = MARK_EMPTY;
        tbl_key[i]  = '0;
        tbl_hook[i] = '0;
      end
      live_cnt = 0;
      outcome_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        outcome_q.push_back(table_apply(cmd_e'(s_axis_tuser), s_axis_tdata[63:0],
                                        s_axis_tdata[127:64]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (outcome_q.size() == 0) begin
          $error("result with no request outstanding");
          errors_o++;
        end else begin
          exp_o = outcome_q.pop_front();
          if (m_axis_tuser != exp_o.status) begin
            $error("status: expected %0d, got %0d", exp_o.status, m_axis_tuser);
            errors_o++;
          end
          if (m_axis_tdata[9:0] != exp_o.slot) begin
            $error("slot_index: expected %0d, got %0d", exp_o.slot, m_axis_tdata[9:0]);
            errors_o++;
          end
          if (m_axis_tdata[19:10] != exp_o.occ) begin
            $error("occupancy: expected %0d, got %0d", exp_o.occ, m_axis_tdata[19:10]);
            errors_o++;
          end
        end
      end
      pending_o = outcome_q.size();
    end
  end

endmodule

@@ tb/tb.sv @@
// Top of the double-hash table testbench: clock, reset, request stimulus, verdict.
module tb;
  import dht_pkg::*;

  localparam int STALL_LIMIT = 400000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [23:0]  m_axis_tdata;
  logic [2:0]   m_axis_tuser;

  int errors, pending;
  int src_idle, sink_stall;
  int quiet_cycles;
  int n_insert, n_erase;
  logic [127:0] pair_pool[$];   // {hook, key} pairs sent as inserts

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  double_hash_table_insert_erase u_dut (.*);

  dht_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= sink_stall);

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL double_hash_table_insert_erase");
      $finish;
    end
  end

  task automatic send_req(cmd_e cmd, logic [63:0] k, logic [63:0] h);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {h, k};
    if (cmd == CMD_INSERT) begin
      n_insert++;
      pair_pool.push_back({h, k});
    end else begin
      n_erase++;
    end
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // mostly well-formed: erases of stored pairs, inserts of fresh or repeated keys
  task automatic random_req();
    logic [127:0] p;
    if ($urandom_range(99) < 45 && pair_pool.size() > 0) begin
      p = pair_pool[$urandom_range(pair_pool.size() - 1)];
      if ($urandom_range(99) < 15) p[64 + $urandom_range(63)] ^= 1'b1;
      send_req(CMD_ERASE, p[63:0], p[127:64]);
    end else if ($urandom_range(99) < 25 && pair_pool.size() > 0) begin
      p = pair_pool[$urandom_range(pair_pool.size() - 1)];
      send_req(CMD_INSERT, p[63:0], rand64());
    end else if ($urandom_range(99) < 10) begin
      send_req(CMD_ERASE, rand64(), rand64());
    end else begin
      send_req(CMD_INSERT, rand64(), rand64());
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  initial begin
    src_idle   = 21;
    sink_stall = 55;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, duplicate, wrong hook, erase twice, reuse of deleted slot
    send_req(CMD_INSERT, '0, '0);
    send_req(CMD_INSERT, '1, '1);
    send_req(CMD_INSERT, '0, 64'h5555_5555_5555_5555);
    send_req(CMD_ERASE,  '0, '1);
    send_req(CMD_ERASE,  '1, '1);
    send_req(CMD_ERASE,  '1, '1);
    send_req(CMD_INSERT, '1, 64'hAAAA_AAAA_AAAA_AAAA);
    send_req(CMD_INSERT, '1, '0);
    send_req(CMD_ERASE,  '1, 64'hAAAA_AAAA_AAAA_AAAA);
    send_req(CMD_ERASE,  '0, '0);
    send_req(CMD_ERASE,  '0, '0);
    for (int i = 1; i <= 6; i++) send_req(CMD_INSERT, 64'(i), 64'(i * 3));
    for (int i = 6; i >= 1; i -= 2) send_req(CMD_ERASE, 64'(i), 64'(i * 3));
    send_req(CMD_INSERT, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001);

    repeat (310) random_req();
    src_idle   = 55;
    sink_stall = 21;
    repeat (310) random_req();

    // hold off until the block is empty of work, then fill the table to overflow
    drain();
    src_idle   = 0;
    sink_stall = 0;
    repeat (1000) send_req(CMD_INSERT, rand64(), rand64());
    for (int i = 0; i < 4; i++) begin
      random_req();
      send_req(CMD_INSERT, rand64(), rand64());
    end
    drain();
    repeat (100) @(posedge clk_i);

    $display("Sent %0d requests: %0d inserts, %0d erases, under three stall mixes,",
             n_insert + n_erase, n_insert, n_erase);
    $display("including a fill of the table past capacity.");
    if (errors == 0) begin
      $display("PASS double_hash_table_insert_erase");
    end else begin
      $display("FAIL double_hash_table_insert_erase");
    end
    $finish;
  end

endmodule

@@ double_hash_table_insert_erase.f @@
src/dht_pkg.sv
src/dht_hash.sv
src/double_hash_table_insert_erase.sv
tb/dht_checker.sv
tb/tb.sv
